[hw/rtl/bounded_list_engine_core_macros.svh]
// Assertion macros used by the bounded list engine checker.
`ifndef BOUNDED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded list engine check failed");

`endif

[hw/rtl/ble_pkg.sv]
// Package: types, codes and sizing constants of the bounded list engine.
`default_nettype none
package ble_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
  localparam int VAL_W    = 64;
  localparam int GRP      = 8;
  localparam int GRP_W    = 3;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
  localparam int GIDX_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NPAD     = NGRP * GRP;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_LOCATE = 2'd3
  } ble_cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_BADPOS   = 2'd2,
    STS_NOTFOUND = 2'd3
  } ble_status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_INSERT,
    OP_DELETE,
    OP_LOCATE
  } ble_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } ble_state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    ble_op_t            op;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   del_idx;
  } ble_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/ble_cell.sv]
// One list slot: holds an entry, shifts with its neighbours, compares on locate.
`default_nettype none
module ble_cell (
  input  wire logic                      clk,
  input  wire ble_pkg::ble_ctrl_t        ctrl,
  input  wire logic [ble_pkg::IDX_W-1:0] idx,
  input  wire logic [ble_pkg::VAL_W-1:0] left_data,
  input  wire logic [ble_pkg::VAL_W-1:0] right_data,
  output logic      [ble_pkg::VAL_W-1:0] data,
  output logic                           match
);
  import ble_pkg::*;

  logic [VAL_W-1:0] data_r, data_nxt;
  logic             match_r, match_nxt;
  logic [CNT_W-1:0] idx_c;

  assign idx_c = CNT_W'(idx);

  always_comb begin
    data_nxt  = data_r;
    match_nxt = 1'b0;
    unique case (ctrl.op)
      OP_APPEND: begin
        if (idx_c == ctrl.count) data_nxt = ctrl.value;
      end
      OP_INSERT: begin
        if (idx_c == '0) data_nxt = ctrl.value;
        else if (idx_c <= ctrl.count) data_nxt = left_data;
      end
      OP_DELETE: begin
        // close the gap: each live slot from the deleted one up, bar the last, pulls from the right
        if ((idx_c >= ctrl.del_idx) && ((idx_c + CNT_W'(1)) < ctrl.count))
          data_nxt = right_data;
      end
      OP_LOCATE: begin
        match_nxt = (idx_c < ctrl.count) && (data_r == ctrl.value);
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule
`default_nettype wire

[hw/rtl/ble_first_match.sv]
// Two-stage registered priority encoder over the cell match flags.
`default_nettype none
module ble_first_match (
  input  wire logic                      clk,
  input  wire logic [ble_pkg::NPAD-1:0]  match_vec,
  output logic                           hit,
  output logic      [ble_pkg::IDX_W-1:0] hit_idx
);
  import ble_pkg::*;

  logic [NGRP-1:0]  grp_any_r;
  logic [GRP_W-1:0] grp_lo_r [NGRP];
  logic [GRP_W-1:0] grp_lo_nxt [NGRP];
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // first stage: per-group any and lowest set bit
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_lo_nxt[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (match_vec[g*GRP + b]) grp_lo_nxt[g] = GRP_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_r[g] <= |match_vec[g*GRP +: GRP];
      grp_lo_r[g]  <= grp_lo_nxt[g];
    end
  end

  // second stage: lowest group with a hit
  always_comb begin
    hit_nxt = 1'b0;
    idx_nxt = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        hit_nxt = 1'b1;
        idx_nxt = IDX_W'({GIDX_W'(g), grp_lo_r[g]});
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    idx_r <= idx_nxt;
  end

  assign hit     = hit_r;
  assign hit_idx = idx_r;

endmodule
`default_nettype wire

[hw/rtl/bounded_list_engine_core.sv]
// Top level of the bounded list engine: cell chain, match finder and command control.
//
// An ordered list of up to CAPACITY 64-bit words held in a row of cells,
// one entry per cell. A command transfer happens at a clock edge where start
// is high and busy is low; in_cmd selects append, insert at front, delete at
// a 1-based position or locate a value.
// At the accepting edge every cell loads, shifts towards its upper or lower
// neighbour, or compares its word against in_value, all at once.
// Locate then walks the match flags through a two-stage priority encoder
// (eight-flag groups, then the first group with a hit).
// Every command answers with one result, out_valid high for exactly one
// cycle, in the done state after the exec and scan states. The receiver
// cannot stall, so the result is simply shown and dropped.
// A new command waits while one is in flight: busy is high in the exec and
// scan states while the finder stages work, and a new command may transfer
// in the same cycle the previous result is shown.
// Reset (rst_n low, synchronous) empties the list and returns to idle; the
// cell words are left as they are and are never read beyond the count.
`default_nettype none
module bounded_list_engine_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_cmd,
  input  wire logic [ble_pkg::VAL_W-1:0] in_value,
  input  wire logic [7:0]                in_position,
  output logic                           out_valid,
  output logic      [1:0]                out_status,
  output logic      [7:0]                out_found_position,
  output logic      [7:0]                out_entry_count
);
  import ble_pkg::*;

  ble_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  ble_cmd_t         cmd_r;
  ble_status_t      status_r, status_nxt;
  ble_ctrl_t        ctrl;
  logic             accept;
  logic             list_full;
  logic             pos_bad;
  logic [CMP_W-1:0] pos_c;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [NPAD-1:0]  match_vec;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  // ---------------------------------------------------------------
  // Handshake and sequencing
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        busy      = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        busy      = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        // take the next command while this result is shown
        state_nxt = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign accept = start && !busy;

  // ---------------------------------------------------------------
  // Command decode: decide the status and what the cells do
  // ---------------------------------------------------------------
  assign list_full = (count_r == CNT_W'(CAPACITY));
  assign pos_c     = CMP_W'(in_position);
  assign pos_bad   = (pos_c == '0) || (pos_c > CMP_W'(count_r));

  always_comb begin
    ctrl.op      = OP_NONE;
    ctrl.value   = in_value;
    ctrl.count   = count_r;
    ctrl.del_idx = CNT_W'(pos_c - CMP_W'(1));
    status_nxt   = STS_OK;
    count_nxt    = count_r;
    if (accept) begin
      unique case (in_cmd)
        CMD_APPEND, CMD_INSERT: begin
          if (list_full) begin
            status_nxt = STS_FULL;
          end else begin
            ctrl.op   = (in_cmd == CMD_APPEND) ? OP_APPEND : OP_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_DELETE: begin
          if (pos_bad) begin
            status_nxt = STS_BADPOS;
          end else begin
            ctrl.op   = OP_DELETE;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          // locate: the finder settles the final status
          ctrl.op    = OP_LOCATE;
          status_nxt = STS_NOTFOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // hold the command and its status for the result cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= ble_cmd_t'(in_cmd);
      status_r <= status_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Cell chain: cell i holds entry i; neighbours feed the shifts
  // ---------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_w;
    logic [VAL_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    ble_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(g)),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .match      (match_vec[g])
    );
  end

  // pad the match vector out to whole groups
  if (NPAD > CAPACITY) begin : g_pad
    assign match_vec[NPAD-1:CAPACITY] = '0;
  end

  ble_first_match u_find (
    .clk       (clk),
    .match_vec (match_vec),
    .hit       (hit),
    .hit_idx   (hit_idx)
  );

  // ---------------------------------------------------------------
  // Result: shown for one cycle in the done state
  // ---------------------------------------------------------------
  always_comb begin
    out_status         = status_r;
    out_found_position = '0;
    if (cmd_r == CMD_LOCATE && hit) begin
      out_status         = STS_OK;
      out_found_position = 8'(CNT_W'(hit_idx) + CNT_W'(1));
    end
  end

  assign out_entry_count = 8'(count_r);

endmodule
`default_nettype wire

[hw/rtl/ble_checker.sv]
// Port-level checker for the bounded list engine, bound to the top level.
`default_nettype none
`include "bounded_list_engine_core_macros.svh"
module ble_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [1:0]                out_status,
  input wire logic [7:0]                out_found_position,
  input wire logic [7:0]                out_entry_count
);
  import ble_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // a transfer locks out the next one while the finder works
  `BLE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, acc, busy)
  // the result follows the transfer through the exec and scan states
  `BLE_ASSERT_SAME(a_latency, clk, rst_n, acc, ##3 out_valid)
  // the strobe is a single-cycle pulse
  `BLE_ASSERT_NEXT(a_strobe_pulse, clk, rst_n, out_valid, !out_valid)
  // no position reported unless the command succeeded
  `BLE_ASSERT_SAME(a_no_pos_on_fail, clk, rst_n, out_valid && (out_status != STS_OK), out_found_position == 8'd0)
  // a reported position lies inside the list
  `BLE_ASSERT_SAME(a_pos_in_list, clk, rst_n, out_valid, out_found_position <= out_entry_count)

endmodule

bind bounded_list_engine_core ble_checker u_ble_checker (.*);
`default_nettype wire
